// File: sv/rtlpm_pkg.sv
package rtlpm_pkg;

    localparam int ROUTE_ENTRIES = 16;
    localparam int IDX_W         = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int ADDR_W        = 32;
    localparam int HANDLE_W      = 8;
    localparam int PLEN_W        = 6;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int IN_DATA_W     = 2 * ADDR_W + HANDLE_W;
    localparam int OUT_DATA_W    = HANDLE_W;
    localparam int OUT_USER_W    = 1 + STATUS_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_UPSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_UPDATED = 2'd1,
        STATUS_INSERTED = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic                active;
        op_t                 op;
        logic [ADDR_W-1:0]   dst;
        logic [ADDR_W-1:0]   msk;
        logic [HANDLE_W-1:0] hnd;
        logic                found;
        logic [PLEN_W-1:0]   best;
        logic [HANDLE_W-1:0] best_h;
        logic                have_def;
        logic [HANDLE_W-1:0] def_h;
        logic                updated;
        logic                have_free;
        logic [IDX_W-1:0]    free_slot;
    } token_t;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    slot;
        logic [ADDR_W-1:0]   dst;
        logic [ADDR_W-1:0]   msk;
        logic [HANDLE_W-1:0] hnd;
        logic [PLEN_W-1:0]   plen;
    } wr_t;

endpackage

// File: sv/rtlpm_cell.sv
module rtlpm_cell
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [rtlpm_pkg::IDX_W-1:0] cell_idx,
    input  rtlpm_pkg::token_t        tok_in,
    input  rtlpm_pkg::wr_t           wr,
    output rtlpm_pkg::token_t        tok_out
);
    import rtlpm_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [ADDR_W-1:0]   dest_reg;
    logic [ADDR_W-1:0]   dest_next;
    logic [ADDR_W-1:0]   mask_reg;
    logic [ADDR_W-1:0]   mask_next;
    logic [HANDLE_W-1:0] handle_reg;
    logic [HANDLE_W-1:0] handle_next;
    logic [PLEN_W-1:0]   plen_reg;
    logic [PLEN_W-1:0]   plen_next;
    token_t              tok_reg;
    token_t              tok_next;

    always_comb
    begin
        valid_next  = valid_reg;
        dest_next   = dest_reg;
        mask_next   = mask_reg;
        handle_next = handle_reg;
        plen_next   = plen_reg;
        tok_next    = tok_in;
        if (tok_in.active)
        begin
            unique case (tok_in.op)
                OP_LOOKUP:
                begin
                    if (valid_reg)
                    begin
                        if (mask_reg == '0)
                        begin
                            tok_next.have_def = 1'b1;
                            tok_next.def_h    = handle_reg;
                        end
                        else if ((((tok_in.dst ^ dest_reg) & mask_reg) == '0)
                                 && (!tok_in.found || plen_reg >= tok_in.best))
                        begin
                            tok_next.found  = 1'b1;
                            tok_next.best   = plen_reg;
                            tok_next.best_h = handle_reg;
                        end
                    end
                end
                OP_UPSERT:
                begin
                    if (!tok_in.updated)
                    begin
                        if (valid_reg && dest_reg == tok_in.dst && mask_reg == tok_in.msk)
                        begin
                            handle_next      = tok_in.hnd;
                            tok_next.updated = 1'b1;
                        end
                        else if (!valid_reg && !tok_in.have_free)
                        begin
                            tok_next.have_free = 1'b1;
                            tok_next.free_slot = cell_idx;
                        end
                    end
                end
                OP_DELETE:
                begin
                    if (valid_reg && handle_reg == tok_in.hnd)
                    begin
                        valid_next = 1'b0;
                    end
                end
                OP_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
        else if (wr.en && wr.slot == cell_idx)
        begin
            valid_next  = 1'b1;
            dest_next   = wr.dst;
            mask_next   = wr.msk;
            handle_next = wr.hnd;
            plen_next   = wr.plen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg   <= dest_next;
        mask_reg   <= mask_next;
        handle_reg <= handle_next;
        plen_reg   <= plen_next;
    end

    assign tok_out = tok_reg;

endmodule

// File: sv/ipv4_route_table_lpm_unit.sv
// Channel   Direction  Signals                 Contents
// s_*       in         s_tdata[71:0], s_tuser  dst_addr, net_mask, if_handle; opcode
// m_*       out        m_tdata[7:0], m_tuser   route_handle; hit, status
//
// One operation is in the table at a time: it passes one entry cell per clock,
// so m_tvalid rises once it has passed every cell and both result stages, and the
// next transaction is taken on the cycle after the result leaves the hold stage.
// A stalled result waits in the output register while the next operation runs.
// Reset empties the table and both result stages at once.
module ipv4_route_table_lpm_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rtlpm_pkg::IN_DATA_W-1:0]  s_tdata,   // dst_addr, net_mask, if_handle
    input  logic [rtlpm_pkg::OP_W-1:0]       s_tuser,   // opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rtlpm_pkg::OUT_DATA_W-1:0] m_tdata,   // route_handle
    output logic [rtlpm_pkg::OUT_USER_W-1:0] m_tuser    // hit, status
);
    import rtlpm_pkg::*;

    token_t tok [0:ROUTE_ENTRIES];
    token_t tail;
    wr_t    wr;

    logic                  accept;
    logic                  out_free;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    logic                  res_hit_reg;
    logic                  res_hit_next;
    logic [HANDLE_W-1:0]   res_handle_reg;
    logic [HANDLE_W-1:0]   res_handle_next;
    status_t               res_status_reg;
    status_t               res_status_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;
    logic [OUT_USER_W-1:0] m_tuser_reg;
    logic [OUT_USER_W-1:0] m_tuser_next;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        tok[0]        = '0;
        tok[0].active = accept;
        tok[0].op     = op_t'(s_tuser);
        tok[0].dst    = s_tdata[ADDR_W-1:0];
        tok[0].msk    = s_tdata[2*ADDR_W-1:ADDR_W];
        tok[0].hnd    = s_tdata[IN_DATA_W-1:2*ADDR_W];
    end

    for (genvar i = 0; i < ROUTE_ENTRIES; i++)
    begin : g_cell
        rtlpm_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .tok_in   (tok[i]),
            .wr       (wr),
            .tok_out  (tok[i+1])
        );
    end

    assign tail = tok[ROUTE_ENTRIES];

    always_comb
    begin
        wr.en   = tail.active && tail.op == OP_UPSERT && !tail.updated && tail.have_free;
        wr.slot = tail.free_slot;
        wr.dst  = tail.dst;
        wr.msk  = tail.msk;
        wr.hnd  = tail.hnd;
        wr.plen = PLEN_W'($countones(tail.msk));
    end

    always_comb
    begin
        res_hit_next    = 1'b0;
        res_handle_next = '0;
        res_status_next = STATUS_DONE;
        unique case (tail.op)
            OP_LOOKUP:
            begin
                if (tail.found)
                begin
                    res_hit_next    = 1'b1;
                    res_handle_next = tail.best_h;
                end
                else if (tail.have_def)
                begin
                    res_hit_next    = 1'b1;
                    res_handle_next = tail.def_h;
                end
            end
            OP_UPSERT:
            begin
                if (tail.updated)
                begin
                    res_status_next = STATUS_UPDATED;
                end
                else if (tail.have_free)
                begin
                    res_status_next = STATUS_INSERTED;
                end
                else
                begin
                    res_status_next = STATUS_FULL;
                end
            end
            default:
            begin
                res_status_next = STATUS_DONE;
            end
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        res_valid_next = res_valid_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (tail.active)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && out_free)
        begin
            res_valid_next = 1'b0;
            busy_next      = 1'b0;
            m_tvalid_next  = 1'b1;
            m_tdata_next   = res_handle_reg;
            m_tuser_next   = {res_status_reg, res_hit_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.active)
        begin
            res_hit_reg    <= res_hit_next;
            res_handle_reg <= res_handle_next;
            res_status_reg <= res_status_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: sv/rtlpm_checker.sv
module rtlpm_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [rtlpm_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic [rtlpm_pkg::OP_W-1:0]       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rtlpm_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [rtlpm_pkg::OUT_USER_W-1:0] m_tuser
);
    import rtlpm_pkg::*;

    // Only one operation may be in the table at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("transaction accepted while an operation is in flight");

    // A stalled result must hold.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A miss carries a zero handle.
    a_miss_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("result without hit carries a handle");

    // A hit only comes from a lookup, whose status is done.
    a_hit_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[OUT_USER_W-1:1] == STATUS_DONE)
        else $error("hit reported with a non-lookup status");

endmodule

bind ipv4_route_table_lpm_unit rtlpm_checker u_rtlpm_checker (.*);
